>>> rtl/bpvf_pkg.sv
package bpvf_pkg;

	localparam int MEDIAN_TAPS = 5;
	localparam int MEAN_TAPS   = 5;
	localparam int NAXES       = 3;

	localparam int COORD_W = 12;
	localparam int DELTA_W = 32;
	localparam int GAIN_W  = 32;
	localparam int FOCAL_W = 22;
	localparam int POS_W   = 28;
	localparam int VEL_W   = 32;
	localparam int CFG_W   = 32;

	localparam int CTR_W   = COORD_W + 9;
	localparam int DVD_W   = CTR_W + POS_W;
	localparam int DVS_W   = 32;
	localparam int CNT_W   = $clog2(DVD_W + 1);
	localparam int SUM_W   = POS_W + $clog2(MEAN_TAPS);
	localparam int VMAG_W  = POS_W + 10;
	localparam int RANK_W  = $clog2(MEDIAN_TAPS + 1);
	localparam int MED_LO  = (MEDIAN_TAPS - 1) / 2;
	localparam int MED_HI  = MEDIAN_TAPS / 2;

	localparam int IN_W    = 4 * COORD_W + DELTA_W;
	localparam int OUT_W   = ((3 * POS_W + 3 * VEL_W + 7) / 8) * 8;

	localparam logic [POS_W-1:0] POS_MAX = '1;

	typedef enum logic [0:0] {
		REG_DEPTH_GAIN   = 1'b0,
		REG_FOCAL_LENGTH = 1'b1
	} reg_index_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_RUN,
		S_POST,
		S_SHIFT,
		S_MED,
		S_OUT
	} state_t;

	typedef enum logic [2:0] {
		OP_Z,
		OP_MUL,
		OP_LAT,
		OP_MEAN,
		OP_VEL
	} op_t;

	function automatic logic [POS_W-1:0] sat_pos(input logic [DVD_W-1:0] v);
		sat_pos = (v > DVD_W'(POS_MAX)) ? POS_MAX : v[POS_W-1:0];
	endfunction

endpackage

>>> rtl/bbox_position_velocity_filter_top.sv
// Bounding-box range and position filter. Each request (box corner, size and
// frame time delta) yields one result: x, y, z positions after a 5-sample
// median and a 5-sample mean, and the velocities, all Q.8. One shared
// bit-serial unit does every multiply (one bit a cycle) and divide (one
// quotient bit a cycle). With a box width of zero or one the depth and lateral
// steps are skipped, and with focal_length zero the lateral steps are skipped.
// After the output step the sequencer returns to idle before it takes the next
// request, and it stalls in its output step only while the result register
// still holds an untaken result. The result register lets the next request
// start while a result waits on m_tready.
// Windows and the previous position clear at reset.
module bbox_position_velocity_filter_top
	import bpvf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [0:0]           wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// box_left, box_top, box_width, box_height, time_delta_us
	input  logic [IN_W-1:0]      s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, zero pad
	output logic [OUT_W-1:0]     m_tdata,
	// width_invalid, delta_invalid
	output logic [1:0]           m_tuser
);

	state_t state_q, state_d;
	op_t    op_q;
	logic [1:0] axis_q;

	logic [GAIN_W-1:0]  gain_q;
	logic [FOCAL_W-1:0] focal_q;

	logic [COORD_W-1:0] left_q, top_q, wid_q, hgt_q;
	logic [DELTA_W-1:0] delta_q;
	logic               winv_q, dinv_q;

	logic [DVD_W-1:0] dvd_q, quo_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic [POS_W-1:0] z_q;

	logic [POS_W-1:0] smp_q  [NAXES];
	logic [POS_W-1:0] filt_q [NAXES];
	logic [POS_W-1:0] prev_q [NAXES];
	logic [VEL_W-1:0] vel_q  [NAXES];
	logic [POS_W-1:0] raw_q  [NAXES][MEDIAN_TAPS];
	logic [POS_W-1:0] mwin_q [NAXES][MEAN_TAPS];

	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;
	logic [1:0]       m_tuser_q;

	logic accept, out_free, out_load;

	// serial step
	logic [DVS_W:0]   rsh;
	logic             ge;
	logic [DVS_W:0]   rdiff;

	// operand formation
	logic [CTR_W-1:0]  ctr;
	logic [SUM_W-1:0]  msum;
	logic              vneg;
	logic [POS_W-1:0]  vmag;
	logic [VMAG_W-1:0] vmag1000;
	logic [VEL_W-1:0]  vres;

	// median
	logic [RANK_W-1:0] rank [MEDIAN_TAPS];
	logic [POS_W-1:0]  med_lo, med_hi, med;
	logic [POS_W:0]    med_sum;

	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept)
					state_d = (s_tdata[3*COORD_W-1:2*COORD_W] >= COORD_W'(2)) ? S_PREP : S_SHIFT;
			end
			S_PREP: state_d = S_RUN;
			S_RUN: begin
				if (cnt_q == CNT_W'(1))
					state_d = S_POST;
			end
			S_POST: begin
				case (op_q)
					OP_Z:    state_d = (focal_q == '0) ? S_SHIFT : S_PREP;
					OP_LAT:  state_d = (axis_q == 2'd1) ? S_SHIFT : S_PREP;
					OP_VEL:  state_d = (axis_q == 2'd2) ? S_OUT : S_PREP;
					default: state_d = S_PREP;
				endcase
			end
			S_SHIFT: state_d = S_MED;
			S_MED: begin
				if (axis_q == 2'd2)
					state_d = S_PREP;
			end
			S_OUT: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		out_free = !m_tvalid_q || m_tready;
		s_tready = (state_q == S_IDLE);
		out_load = (state_q == S_OUT) && out_free;
	end

	always_comb begin
		rsh   = {rem_q, dvd_q[DVD_W-1]};
		ge    = rsh >= {1'b0, dvs_q};
		rdiff = rsh - {1'b0, dvs_q};
	end

	always_comb begin
		ctr = (axis_q == 2'd0) ? ({1'b0, left_q, 8'b0} + {2'b0, wid_q, 7'b0})
		                       : ({1'b0, top_q, 8'b0} + {2'b0, hgt_q, 7'b0});
		msum = '0;
		for (int i = 0; i < MEAN_TAPS; i++)
			msum = msum + SUM_W'(mwin_q[axis_q][i]);
		vneg = filt_q[axis_q] < prev_q[axis_q];
		vmag = vneg ? (prev_q[axis_q] - filt_q[axis_q]) : (filt_q[axis_q] - prev_q[axis_q]);
		vmag1000 = (VMAG_W'(vmag) << 10) - (VMAG_W'(vmag) << 4) - (VMAG_W'(vmag) << 3);
		if (vneg)
			vres = (quo_q > DVD_W'(33'h80000000)) ? 32'h80000000 : (32'd0 - quo_q[VEL_W-1:0]);
		else
			vres = (quo_q > DVD_W'(32'h7fffffff)) ? 32'h7fffffff : quo_q[VEL_W-1:0];
	end

	always_comb begin
		med_lo = '0;
		med_hi = '0;
		for (int i = 0; i < MEDIAN_TAPS; i++) begin
			rank[i] = '0;
			for (int j = 0; j < MEDIAN_TAPS; j++) begin
				if (raw_q[axis_q][j] < raw_q[axis_q][i] ||
				    (raw_q[axis_q][j] == raw_q[axis_q][i] && j < i))
					rank[i] = rank[i] + RANK_W'(1);
			end
			if (rank[i] == RANK_W'(MED_LO))
				med_lo = raw_q[axis_q][i];
			if (rank[i] == RANK_W'(MED_HI))
				med_hi = raw_q[axis_q][i];
		end
		med_sum = {1'b0, med_lo} + {1'b0, med_hi};
		med     = med_sum[POS_W:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			gain_q     <= GAIN_W'(47452160);
			focal_q    <= FOCAL_W'(339341);
			m_tvalid_q <= 1'b0;
			for (int a = 0; a < NAXES; a++) begin
				prev_q[a] <= '0;
				for (int i = 0; i < MEDIAN_TAPS; i++)
					raw_q[a][i] <= '0;
				for (int i = 0; i < MEAN_TAPS; i++)
					mwin_q[a][i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				unique case (reg_index_t'(wr_index))
					REG_DEPTH_GAIN:   gain_q  <= wr_data;
					REG_FOCAL_LENGTH: focal_q <= wr_data[FOCAL_W-1:0];
					default: ;
				endcase
			end
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			if (state_q == S_SHIFT) begin
				for (int a = 0; a < NAXES; a++) begin
					for (int i = 0; i < MEDIAN_TAPS - 1; i++)
						raw_q[a][i] <= raw_q[a][i+1];
					raw_q[a][MEDIAN_TAPS-1] <= smp_q[a];
				end
			end
			if (state_q == S_MED) begin
				for (int i = 0; i < MEAN_TAPS - 1; i++)
					mwin_q[axis_q][i] <= mwin_q[axis_q][i+1];
				mwin_q[axis_q][MEAN_TAPS-1] <= med;
			end
			if (state_q == S_POST && op_q == OP_VEL)
				prev_q[axis_q] <= filt_q[axis_q];
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					left_q  <= s_tdata[COORD_W-1:0];
					top_q   <= s_tdata[2*COORD_W-1:COORD_W];
					wid_q   <= s_tdata[3*COORD_W-1:2*COORD_W];
					hgt_q   <= s_tdata[4*COORD_W-1:3*COORD_W];
					delta_q <= s_tdata[IN_W-1:4*COORD_W];
					winv_q  <= (s_tdata[3*COORD_W-1:2*COORD_W] == '0);
					dinv_q  <= (s_tdata[IN_W-1:4*COORD_W] == '0);
					for (int a = 0; a < NAXES; a++)
						smp_q[a] <= '0;
					op_q   <= OP_Z;
					axis_q <= 2'd0;
				end
			end
			S_PREP: begin
				rem_q <= '0;
				quo_q <= '0;
				case (op_q)
					OP_Z: begin
						dvd_q <= DVD_W'(gain_q) << (DVD_W - GAIN_W);
						dvs_q <= DVS_W'(wid_q);
						cnt_q <= CNT_W'(GAIN_W);
					end
					OP_MUL: begin
						dvd_q <= DVD_W'(ctr) << (DVD_W - CTR_W);
						cnt_q <= CNT_W'(CTR_W);
					end
					OP_LAT: begin
						dvd_q <= quo_q;
						dvs_q <= DVS_W'(focal_q);
						cnt_q <= CNT_W'(DVD_W);
					end
					OP_MEAN: begin
						dvd_q <= DVD_W'(msum) << (DVD_W - SUM_W);
						dvs_q <= DVS_W'(MEAN_TAPS);
						cnt_q <= CNT_W'(SUM_W);
					end
					default: begin
						dvd_q <= DVD_W'(vmag1000) << (DVD_W - VMAG_W);
						dvs_q <= delta_q;
						cnt_q <= CNT_W'(VMAG_W);
					end
				endcase
			end
			S_RUN: begin
				cnt_q <= cnt_q - CNT_W'(1);
				dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
				if (op_q == OP_MUL) begin
					quo_q <= {quo_q[DVD_W-2:0], 1'b0} +
					         (dvd_q[DVD_W-1] ? DVD_W'(z_q) : '0);
				end else begin
					quo_q <= {quo_q[DVD_W-2:0], ge};
					rem_q <= ge ? rdiff[DVS_W-1:0] : rsh[DVS_W-1:0];
				end
			end
			S_POST: begin
				case (op_q)
					OP_Z: begin
						z_q      <= sat_pos(quo_q);
						smp_q[2] <= sat_pos(quo_q);
						if (focal_q == '0) begin
							smp_q[0] <= POS_MAX;
							smp_q[1] <= POS_MAX;
						end
						op_q   <= OP_MUL;
						axis_q <= 2'd0;
					end
					OP_MUL: op_q <= OP_LAT;
					OP_LAT: begin
						smp_q[axis_q] <= sat_pos(quo_q);
						if (axis_q == 2'd0) begin
							axis_q <= 2'd1;
							op_q   <= OP_MUL;
						end
					end
					OP_MEAN: begin
						filt_q[axis_q] <= quo_q[POS_W-1:0];
						if (axis_q == 2'd2) begin
							axis_q <= 2'd0;
							op_q   <= OP_VEL;
						end else begin
							axis_q <= axis_q + 2'd1;
						end
					end
					default: begin
						vel_q[axis_q] <= dinv_q ? '0 : vres;
						axis_q        <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
					end
				endcase
			end
			S_SHIFT: axis_q <= 2'd0;
			S_MED: begin
				axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
				op_q   <= OP_MEAN;
			end
			S_OUT: begin
				if (out_load) begin
					m_tdata_q <= OUT_W'({vel_q[2], vel_q[1], vel_q[0],
					                     filt_q[2], filt_q[1], filt_q[0]});
					m_tuser_q <= {dinv_q, winv_q};
				end
			end
			default: ;
		endcase
	end

endmodule
